### hdl/swm_pkg.sv
// ---------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window minimum
// Sample and configuration widths, the controller state type and the
// command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CFG_W    = 7;

   localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // take the offered sample and start a new scan
      logic read;      // read one older ring entry
      logic load_out;  // move the finished minimum to the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic single;     // the accepted sample is the only one in the window
      logic scan_last;  // the read issued this cycle is the last one
      logic out_free;   // the result register can take a new result
   } status_type;

endpackage

### hdl/swm_channel_if.sv
// ---------------------------------------------------------------------------
// swm_req_if / swm_rsp_if: sample and result channels
// Valid/ready channels; a transfer happens at a rising edge with both high.
// ---------------------------------------------------------------------------
interface swm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [swm_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [swm_pkg::SAMPLE_W-1:0] window_min;
   logic                                window_full;

   modport source (output valid, output window_min, output window_full, input ready);
   modport sink   (input valid, input window_min, input window_full, output ready);
endinterface

### hdl/swm_ctrl.sv
// ---------------------------------------------------------------------------
// swm_ctrl: sequencing of one sample
// Accepts a sample, steps the ring scan, waits for the read pipeline to
// drain and hands the result to the output register.
// ---------------------------------------------------------------------------
module swm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  swm_pkg::status_type   status,
   output swm_pkg::cmd_type      cmd
);

   swm_pkg::state_type state_ff;
   swm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.single ? swm_pkg::ST_FINISH : swm_pkg::ST_SCAN;
            end
         end
         swm_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = swm_pkg::ST_DRAIN;
            end
         end
         swm_pkg::ST_DRAIN: begin
            state_in = swm_pkg::ST_FINISH;
         end
         swm_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = swm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.read     = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         swm_pkg::ST_IDLE: begin
            // Nothing is taken while reset is held.
            req_ready  = !reset;
            cmd.accept = req_valid && !reset;
         end
         swm_pkg::ST_SCAN: begin
            cmd.read = 1'b1;
         end
         swm_pkg::ST_DRAIN: begin
         end
         swm_pkg::ST_FINISH: begin
            cmd.load_out = status.out_free;
         end
         default: begin
         end
      endcase
   end

   // A new sample is taken only from the idle state.
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_ready)
      else $error("swm_ctrl: sample taken while a scan was running");

   // The scan always ends through the drain cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == swm_pkg::ST_DRAIN) |=> (state_ff == swm_pkg::ST_FINISH))
      else $error("swm_ctrl: drain did not lead to finish");

   // A result is loaded only when the output register has room.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("swm_ctrl: result loaded into a full output register");

endmodule

### hdl/swm_datapath.sv
// ---------------------------------------------------------------------------
// swm_datapath: sample ring, scan pointers, running minimum and result
// Holds the window size register, the ring memory with its registered
// read port, the fill count and the output register.
// ---------------------------------------------------------------------------
module swm_datapath #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [swm_pkg::CFG_W-1:0]           csr_write_data,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
   input  swm_pkg::cmd_type                    cmd,
   output swm_pkg::status_type                 status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [swm_pkg::SAMPLE_W-1:0] window_min,
   output logic                                window_full
);

   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int EXT_W  = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;

   logic signed [swm_pkg::SAMPLE_W-1:0] sample_ring [WINDOW_MAX];

   logic [swm_pkg::CFG_W-1:0]           window_size_ff;
   logic [SLOT_W-1:0]                   write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]                   read_slot_ff, read_slot_in;
   logic [CNT_W-1:0]                    fill_count_ff, fill_count_in;
   logic [CNT_W-1:0]                    left_ff, left_in;
   logic signed [swm_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                                rd_valid_ff;
   logic signed [swm_pkg::SAMPLE_W-1:0] best_ff, best_in;
   logic                                full_ff;
   logic                                rsp_valid_ff;
   logic signed [swm_pkg::SAMPLE_W-1:0] out_min_ff;
   logic                                out_full_ff;

   logic [EXT_W-1:0] size_ext;
   logic [EXT_W-1:0] eff_ext;
   logic [CNT_W-1:0] eff_size;
   logic [CNT_W-1:0] fill_next;

   // Effective window: zero acts as one, oversize is clamped to the ring depth.
   always_comb begin
      size_ext = EXT_W'(window_size_ff);
      if (window_size_ff == '0) begin
         eff_ext = EXT_W'(1);
      end else if (size_ext > EXT_W'(WINDOW_MAX)) begin
         eff_ext = EXT_W'(WINDOW_MAX);
      end else begin
         eff_ext = size_ext;
      end
      eff_size = eff_ext[CNT_W-1:0];
   end

   assign fill_next = (fill_count_ff < eff_size) ? fill_count_ff + CNT_W'(1) : eff_size;

   always_comb begin
      write_slot_in = write_slot_ff;
      fill_count_in = fill_count_ff;
      read_slot_in  = read_slot_ff;
      left_in       = left_ff;
      if (cmd.accept) begin
         write_slot_in = (write_slot_ff == SLOT_W'(WINDOW_MAX - 1)) ?
                         '0 : write_slot_ff + SLOT_W'(1);
         fill_count_in = fill_next;
         read_slot_in  = (write_slot_ff == '0) ?
                         SLOT_W'(WINDOW_MAX - 1) : write_slot_ff - SLOT_W'(1);
         left_in       = fill_next - CNT_W'(1);
      end else if (cmd.read) begin
         read_slot_in = (read_slot_ff == '0) ?
                        SLOT_W'(WINDOW_MAX - 1) : read_slot_ff - SLOT_W'(1);
         left_in      = left_ff - CNT_W'(1);
      end
      if (csr_write_enable) begin
         write_slot_in = '0;
         fill_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swm_pkg::WINDOW_SIZE_RESET;
         write_slot_ff  <= '0;
         fill_count_ff  <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_size_ff <= csr_write_data;
         end
         write_slot_ff <= write_slot_in;
         fill_count_ff <= fill_count_in;
         rd_valid_ff   <= cmd.read;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Ring memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ring[write_slot_ff] <= sample;
      end
      if (cmd.read) begin
         rd_data_ff <= sample_ring[read_slot_ff];
      end
   end

   always_comb begin
      best_in = best_ff;
      if (cmd.accept) begin
         best_in = sample;
      end else if (rd_valid_ff && (rd_data_ff < best_ff)) begin
         best_in = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      read_slot_ff <= read_slot_in;
      left_ff      <= left_in;
      best_ff      <= best_in;
      if (cmd.accept) begin
         full_ff <= (fill_next == eff_size);
      end
      if (cmd.load_out) begin
         out_min_ff  <= best_ff;
         out_full_ff <= full_ff;
      end
   end

   assign status.single    = (fill_next == CNT_W'(1));
   assign status.scan_last = (left_ff == CNT_W'(1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign window_min  = out_min_ff;
   assign window_full = out_full_ff;

   // The fill count never passes the effective window.
   assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= eff_size)
      else $error("swm_datapath: fill count beyond window size");

   // Every issued read returns data for the compare in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> rd_valid_ff)
      else $error("swm_datapath: ring read lost");

   // A read is never issued with no older samples left to visit.
   assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> (left_ff != '0))
      else $error("swm_datapath: scan ran past the filled window");

   // A loaded result is offered in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("swm_datapath: loaded result not offered");

endmodule

### hdl/sliding_window_minimum.sv
// ---------------------------------------------------------------------------
// sliding_window_minimum: minimum over the most recent samples of a stream
// Ring-buffer window minimum with a controller and a scanning datapath.
// ---------------------------------------------------------------------------
// Each sample transfer on the request channel produces exactly one result
// transfer: the minimum of the last window_size samples (or of all samples
// since the window restarted, while fewer have arrived) and a flag that is
// set once the window is full. Samples are kept in a ring memory of
// WINDOW_MAX entries with a single registered read port, and the minimum is
// found by reading the older samples one per cycle. A sample is taken, the
// other fill - 1 samples are read, where fill is the number in the window
// after it arrives, the read pipeline drains and the result is loaded; a
// sample that is the only one in the window skips the scan and the drain.
// Only then is a new sample taken. The result sits in an output register,
// so the next sample is taken while an earlier result waits to be picked
// up. A window_size of zero acts as one and a value above WINDOW_MAX acts as
// WINDOW_MAX. Writing window_size restarts the window: the fill count and
// the write position return to zero. The register must only be written
// while the block is idle. The reset value of window_size is 64.
// ---------------------------------------------------------------------------
module sliding_window_minimum #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   swm_req_if.sink                   req_channel,
   swm_rsp_if.source                 rsp_channel,
   input  logic                      csr_write_enable,
   input  logic [swm_pkg::CFG_W-1:0] csr_write_data
);

   swm_pkg::cmd_type    cmd;
   swm_pkg::status_type status;

   // The controller decides when a sample is taken, how long the ring scan
   // runs and when the result may enter the output register.
   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the ring, the window size register, the running
   // minimum and the output register that drives the result channel.
   swm_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .sample           (req_channel.sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_channel.valid),
      .rsp_ready        (rsp_channel.ready),
      .window_min       (rsp_channel.window_min),
      .window_full      (rsp_channel.window_full)
   );

endmodule
